@@ rtl/bva_pkg.sv @@
// package for the bit-vector alu: opcodes, widths and defaults
`default_nettype none
package bva_pkg;
   localparam int DEFAULT_WIDTH = 32;
   localparam int TYPE_W        = 4;
   localparam int DATA_W        = 32;

   typedef enum logic [TYPE_W-1:0] {
      OP_NOT  = 4'd0,
      OP_AND  = 4'd1,
      OP_EQ   = 4'd2,
      OP_ADD  = 4'd3,
      OP_NEG  = 4'd4,
      OP_SUB  = 4'd5,
      OP_MUL  = 4'd6,
      OP_UDIV = 4'd7,
      OP_UREM = 4'd8,
      OP_SHL  = 4'd9,
      OP_SHR  = 4'd10,
      OP_ULT  = 4'd11
   } op_type;
endpackage
`default_nettype wire

@@ rtl/bitvector_alu_core.sv @@
// top level: pipelined bit-vector alu with shift-add multiply and restoring divide
`default_nettype none
// Takes one request per cycle unless the result side stalls, and returns one
// result per request, in order. It has one input stage for the simple operations,
// WIDTH stages that each do one multiply add step and one restoring divide
// step, and the output register. A stall on the result side holds the whole
// pipeline. Operands use their low WIDTH bits; eq and ult give 0 or 1.
module bitvector_alu_core import bva_pkg::*; #(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [DATA_W-1:0] req_operand_a,
   input  wire logic [DATA_W-1:0] req_operand_b,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DATA_W-1:0]      rsp_result
);
   localparam int SHIFT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic                   advance;
   logic                   valid_ff [0:WIDTH];
   logic [TYPE_W-1:0]      op_ff    [0:WIDTH];
   logic [WIDTH-1:0]       a_ff     [0:WIDTH];
   logic [WIDTH-1:0]       b_ff     [0:WIDTH];
   logic [WIDTH-1:0]       simple_ff[0:WIDTH];
   logic [WIDTH-1:0]       prod_ff  [0:WIDTH];
   logic [WIDTH-1:0]       quo_ff   [0:WIDTH];
   logic [WIDTH-1:0]       rem_ff   [0:WIDTH];

   logic [WIDTH-1:0]       a_in;
   logic [WIDTH-1:0]       b_in;
   logic [WIDTH-1:0]       simple_in;
   logic [SHIFT_W-1:0]     amt;
   logic [WIDTH-1:0]       final_in;
   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_result_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   assign a_in = WIDTH'(req_operand_a);
   assign b_in = WIDTH'(req_operand_b);
   assign amt  = b_in[SHIFT_W-1:0];

   always_comb begin
      case (req_type)
         OP_NOT:  simple_in = ~a_in;
         OP_AND:  simple_in = a_in & b_in;
         OP_EQ:   simple_in = WIDTH'(a_in == b_in);
         OP_ADD:  simple_in = a_in + b_in;
         OP_NEG:  simple_in = (~a_in) + WIDTH'(1);
         OP_SUB:  simple_in = a_in - b_in;
         OP_SHL:  simple_in = (WIDTH'(amt) >= WIDTH'(WIDTH)) ? '0 : (a_in << amt);
         OP_SHR:  simple_in = (WIDTH'(amt) >= WIDTH'(WIDTH)) ? '0 : (a_in >> amt);
         OP_ULT:  simple_in = WIDTH'(a_in < b_in);
         default: simple_in = '0;
      endcase
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
      end
      if (advance) begin
         op_ff[0]     <= req_type;
         a_ff[0]      <= a_in;
         b_ff[0]      <= b_in;
         simple_ff[0] <= simple_in;
         prod_ff[0]   <= '0;
         quo_ff[0]    <= '0;
         rem_ff[0]    <= '0;
      end
   end

   // one multiply step and one divide step per stage
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      logic [WIDTH:0]   trial;
      logic             ge;
      logic [WIDTH-1:0] rem_in;
      logic [WIDTH-1:0] prod_in;

      always_comb begin
         trial   = {rem_ff[k], a_ff[k][WIDTH-1-k]};
         ge      = trial >= {1'b0, b_ff[k]};
         rem_in  = ge ? WIDTH'(trial - {1'b0, b_ff[k]}) : WIDTH'(trial);
         prod_in = prod_ff[k] + (a_ff[k][k] ? (b_ff[k] << k) : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (advance) begin
            op_ff[k+1]     <= op_ff[k];
            a_ff[k+1]      <= a_ff[k];
            b_ff[k+1]      <= b_ff[k];
            simple_ff[k+1] <= simple_ff[k];
            prod_ff[k+1]   <= prod_in;
            quo_ff[k+1]    <= {quo_ff[k][WIDTH-2:0], ge};
            rem_ff[k+1]    <= rem_in;
         end
      end
   end

   always_comb begin
      case (op_ff[WIDTH])
         OP_MUL:  final_in = prod_ff[WIDTH];
         OP_UDIV: final_in = (b_ff[WIDTH] == '0) ? '1 : quo_ff[WIDTH];
         OP_UREM: final_in = (b_ff[WIDTH] == '0) ? a_ff[WIDTH] : rem_ff[WIDTH];
         default: final_in = simple_ff[WIDTH];
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[WIDTH];
      end
      if (advance) begin
         rsp_result_ff <= DATA_W'(final_in);
      end
   end
endmodule
`default_nettype wire
